// ===== rtl/keyword_substitution_cipher_assert.svh =====
// Assertion macros for the keyword substitution cipher.
// Used by the top level only; needs no package.
`ifndef KEYWORD_SUBSTITUTION_CIPHER_ASSERT_SVH
`define KEYWORD_SUBSTITUTION_CIPHER_ASSERT_SVH

// Same-cycle implication under reset.
`define KSC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under reset.
`define KSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/kwsc_pkg.sv =====
// Shared types and constants for the keyword substitution cipher.
// No dependencies.
package kwsc_pkg;

  localparam int unsigned ALPHA_SIZE = 26;
  localparam int unsigned KEY_SLOTS  = 16;
  localparam int unsigned KEY_MAX    = 16;
  localparam int unsigned CODE_W     = 5;
  localparam int unsigned KEY_W      = 40;
  localparam int unsigned KLEN_W     = 5;

  localparam logic [7:0] CHAR_UP_A = 8'h41;
  localparam logic [7:0] CHAR_UP_Z = 8'h5a;
  localparam logic [7:0] CHAR_LO_A = 8'h61;
  localparam logic [7:0] CHAR_LO_Z = 8'h7a;
  localparam logic [7:0] CASE_BIT  = 8'h20;

  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  typedef enum logic [1:0] {
    CFG_MODE    = 2'd0,
    CFG_KEY_LEN = 2'd1,
    CFG_KEY_LO  = 2'd2,
    CFG_KEY_HI  = 2'd3
  } cfg_reg_e;

  // One classified character waiting for lookup.
  typedef struct packed {
    logic [7:0]        text;
    logic              last;
    logic              letter;
    logic [CODE_W-1:0] idx;
  } entry_t;

  // Table status and lookup between builder and back end.
  typedef struct packed {
    logic              ready;
    logic [CODE_W-1:0] data;
  } alpha_rsp_t;

endpackage

// ===== rtl/kwsc_front.sv =====
// Front end: takes input words and classifies them as letter or pass-through.
// Depends on kwsc_pkg.
module kwsc_front import kwsc_pkg::*; (
  input  logic       in_valid_i,
  input  logic [7:0] text_byte_i,
  input  logic       last_byte_i,
  input  logic       q_full_i,
  output logic       in_stall_o,
  output logic       push_o,
  output entry_t     push_data_o
);

  logic [7:0] lower;
  logic       is_letter;

  always_comb begin
    lower     = text_byte_i;
    is_letter = 1'b0;
    if (text_byte_i inside {[CHAR_UP_A:CHAR_UP_Z]}) begin
      lower = text_byte_i | CASE_BIT;
    end
    if (lower inside {[CHAR_LO_A:CHAR_LO_Z]}) begin
      is_letter = 1'b1;
    end
  end

  logic [7:0] offset;
  assign offset = lower - CHAR_LO_A;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    push_data_o.text   = text_byte_i;
    push_data_o.last   = last_byte_i;
    push_data_o.letter = is_letter;
    push_data_o.idx    = is_letter ? offset[CODE_W-1:0] : '0;
  end

endmodule

// ===== rtl/kwsc_queue.sv =====
// Short FIFO of classified words between front and back end.
// Depends on kwsc_pkg.
module kwsc_queue import kwsc_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_data_i,
  input  logic   pop_i,
  output entry_t pop_data_o,
  output logic   full_o,
  output logic   empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  entry_t          mem_q [DEPTH];
  logic [PW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]   count_q, count_d;

  assign full_o     = (count_q == CW'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/kwsc_alpha.sv =====
// Configuration registers and alphabet builder; holds the active lookup table.
// Depends on kwsc_pkg.
module kwsc_alpha import kwsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  cfg_reg_e          cfg_idx_i,
  input  logic [KEY_W-1:0]  cfg_data_i,
  input  logic [CODE_W-1:0] rd_idx_i,
  output alpha_rsp_t        rsp_o
);

  typedef enum logic [1:0] {
    B_KEY,
    B_FILL,
    B_DONE
  } build_state_e;

  logic                    mode_q;
  logic [KLEN_W-1:0]       key_len_q;
  logic [2*KEY_W-1:0]      keys_q;

  build_state_e            state_q;
  logic [KLEN_W-1:0]       slot_q;
  logic [CODE_W-1:0]       letter_q;
  logic [CODE_W-1:0]       fill_q;
  logic [ALPHA_SIZE-1:0]   used_q;
  logic [CODE_W-1:0]       map_q [ALPHA_SIZE];

  localparam int unsigned SLOT_LIMIT = (KEY_MAX < KEY_SLOTS) ? KEY_MAX : KEY_SLOTS;

  logic [KLEN_W-1:0] limit;
  logic [CODE_W-1:0] key_code;
  logic [CODE_W-1:0] code;
  logic              wr_en;
  logic [CODE_W-1:0] wr_addr, wr_data;

  assign limit    = (key_len_q > KLEN_W'(SLOT_LIMIT)) ? KLEN_W'(SLOT_LIMIT) : key_len_q;
  assign key_code = keys_q[slot_q[3:0]*CODE_W +: CODE_W];

  always_comb begin
    wr_en = 1'b0;
    code  = letter_q;
    case (state_q)
      B_KEY: begin
        code  = key_code;
        wr_en = (slot_q < limit) && (key_code < CODE_W'(ALPHA_SIZE)) && !used_q[key_code];
      end
      B_FILL: begin
        wr_en = !used_q[letter_q];
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
    // encrypt: table[position] = letter; decrypt: table[letter] = position
    wr_addr = (mode_q == MODE_DECRYPT) ? code : fill_q;
    wr_data = (mode_q == MODE_DECRYPT) ? fill_q : code;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_ENCRYPT;
      key_len_q <= '0;
      keys_q    <= '0;
      state_q   <= B_KEY;
      slot_q    <= '0;
      letter_q  <= '0;
      fill_q    <= '0;
      used_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE:    mode_q               <= cfg_data_i[0];
        CFG_KEY_LEN: key_len_q            <= cfg_data_i[KLEN_W-1:0];
        CFG_KEY_LO:  keys_q[KEY_W-1:0]    <= cfg_data_i;
        CFG_KEY_HI:  keys_q[2*KEY_W-1:KEY_W] <= cfg_data_i;
        default:     mode_q               <= mode_q;
      endcase
      // restart the build from scratch
      state_q  <= B_KEY;
      slot_q   <= '0;
      letter_q <= '0;
      fill_q   <= '0;
      used_q   <= '0;
    end else begin
      case (state_q)
        B_KEY: begin
          if (slot_q < limit) begin
            slot_q <= slot_q + KLEN_W'(1);
            if (wr_en) begin
              used_q[key_code] <= 1'b1;
              fill_q           <= fill_q + CODE_W'(1);
            end
          end else begin
            state_q  <= B_FILL;
            letter_q <= '0;
          end
        end
        B_FILL: begin
          if (wr_en) begin
            fill_q <= fill_q + CODE_W'(1);
          end
          if (letter_q == CODE_W'(ALPHA_SIZE - 1)) begin
            state_q <= B_DONE;
          end else begin
            letter_q <= letter_q + CODE_W'(1);
          end
        end
        default: begin
          state_q <= B_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && !cfg_we_i) begin
      map_q[wr_addr] <= wr_data;
    end
  end

  assign rsp_o.ready = (state_q == B_DONE);
  assign rsp_o.data  = map_q[rd_idx_i];

endmodule

// ===== rtl/kwsc_back.sv =====
// Back end: pops classified words, looks up letters, holds the output register.
// Depends on kwsc_pkg.
module kwsc_back import kwsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  entry_t            q_data_i,
  output logic              pop_o,
  output logic [CODE_W-1:0] rd_idx_o,
  input  alpha_rsp_t        rsp_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        out_byte_o,
  output logic              out_last_o
);

  logic       out_valid_q;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q;

  assign rd_idx_o = q_data_i.idx;
  assign pop_o    = !q_empty_i && rsp_i.ready && (!out_valid_q || !out_stall_i);

  assign out_byte_d = q_data_i.letter ? (CHAR_LO_A + {3'b000, rsp_i.data}) : q_data_i.text;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // hold the word while the receiver stalls
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_byte_q <= out_byte_d;
      out_last_q <= q_data_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== rtl/keyword_substitution_cipher.sv =====
// Keyword substitution cipher, top level: front end, queue, builder, back end.
// Depends on kwsc_pkg, kwsc_front, kwsc_queue, kwsc_alpha, kwsc_back and the assert header.
//
// Input channel: in_valid_i / in_stall_o carry text_byte_i and last_byte_i, one
// character per word. Output channel: out_valid_o / out_stall_i carry out_byte_o
// and out_last_o. A word moves at a clock edge with valid high and stall low.
// Letters of either case map to a lower-case letter through the table; every
// other byte passes unchanged. out_last_o copies last_byte_i.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i (mode, key
// length, key letters 0..7, key letters 8..15); the user writes only while the
// block is idle, and the block itself does not enforce it. After reset and
// after every configuration write the builder walks the key slots, then the 26
// letters, one per cycle. Words are accepted into the queue meanwhile and wait
// there until the table is done. A word goes from the queue into the output
// register. Throughput: one word per cycle when the table is ready and the
// receiver does not stall, set by the single table read in the back end.
// A stalled receiver holds the output register; the queue fills and then
// in_stall_o rises until the output drains.
`include "keyword_substitution_cipher_assert.svh"

module keyword_substitution_cipher import kwsc_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [KEY_W-1:0]  cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        text_byte_i,
  input  logic              last_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        out_byte_o,
  output logic              out_last_o
);

  logic              push, pop, q_full, q_empty;
  entry_t            push_data, pop_data;
  logic [CODE_W-1:0] rd_idx;
  alpha_rsp_t        alpha_rsp;

  kwsc_front u_front (
    .in_valid_i  (in_valid_i),
    .text_byte_i (text_byte_i),
    .last_byte_i (last_byte_i),
    .q_full_i    (q_full),
    .in_stall_o  (in_stall_o),
    .push_o      (push),
    .push_data_o (push_data)
  );

  kwsc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  kwsc_alpha u_alpha (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_reg_e'(cfg_idx_i)),
    .cfg_data_i (cfg_data_i),
    .rd_idx_i   (rd_idx),
    .rsp_o      (alpha_rsp)
  );

  kwsc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (pop_data),
    .pop_o       (pop),
    .rd_idx_o    (rd_idx),
    .rsp_i       (alpha_rsp),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

  `KSC_ASSERT_NEXT(a_cfg_restarts_build, clk_i, rst_ni, cfg_we_i, !alpha_rsp.ready,
    "config write did not restart the build")

  `KSC_ASSERT_NEXT(a_no_output_while_building, clk_i, rst_ni, !alpha_rsp.ready,
    !out_valid_o || $past(out_valid_o && out_stall_i), "word issued before table was built")

  `KSC_ASSERT_NEXT(a_drain_when_empty, clk_i, rst_ni, out_valid_o && !out_stall_i && q_empty,
    !out_valid_o, "word issued from an empty queue")

  `KSC_ASSERT_NOW(a_pop_needs_data, clk_i, rst_ni, pop, !q_empty && alpha_rsp.ready,
    "pop without data or table")

endmodule
